/* hdl/wfsc_pkg.sv */
`timescale 1ns / 1ps

package wfsc_pkg;

  // Field widths
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DistW    = 16;
  localparam int unsigned ClampW   = 11;
  localparam int unsigned SpeedW   = 11;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  // Distance clamps in 1/16 cm
  localparam logic [DistW-1:0]  DeadZone = 16'd40;
  localparam logic [DistW-1:0]  FarLimit = 16'd1920;
  localparam logic [ClampW-1:0] FarValue = 11'd1600;

  // Steering limits
  localparam logic signed [12:0] SatCorr     = 13'sd180;
  localparam logic signed [8:0]  SatCorrPos  = 9'sd180;
  localparam logic signed [8:0]  SatCorrNeg  = -9'sd180;
  localparam logic signed [8:0]  StrongPos   = 9'sd250;
  localparam logic signed [8:0]  StrongNeg   = -9'sd250;
  localparam logic signed [11:0] SpeedMax    = 12'sd1250;

  typedef enum logic [1:0] {
    TRIG_NONE   = 2'd0,
    TRIG_LEFT   = 2'd1,
    TRIG_CENTER = 2'd2,
    TRIG_RIGHT  = 2'd3
  } trig_e;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_STOP       = 3'd1,
    ACT_TURN_LEFT  = 3'd2,
    ACT_TURN_RIGHT = 3'd3,
    ACT_FORWARD    = 3'd4
  } act_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_SLOT_PERIOD   = 3'd0,
    REG_TURN_TIMEOUT  = 3'd1,
    REG_TURN_COOLDOWN = 3'd2,
    REG_CORNER_DIST   = 3'd3,
    REG_CLEAR_DIST    = 3'd4,
    REG_NEAR_WALL     = 3'd5,
    REG_CRUISE_SPEED  = 3'd6,
    REG_TURN_SPEED    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [9:0]  slot_period_ms;
    logic [13:0] turn_timeout_ms;
    logic [13:0] turn_cooldown_ms;
    logic [11:0] corner_distance;
    logic [11:0] clear_distance;
    logic [11:0] near_wall_distance;
    logic [9:0]  cruise_speed;
    logic [9:0]  turn_speed;
  } cfg_t;

  // Zero the dead zone, pull far readings in to the far value
  function automatic logic [ClampW-1:0] clamp_dist(input logic [DistW-1:0] d);
    logic [ClampW-1:0] v;
    if (d <= DeadZone) begin
      v = '0;
    end else if (d > FarLimit) begin
      v = FarValue;
    end else begin
      v = d[ClampW-1:0];
    end
    return v;
  endfunction

endpackage

/* hdl/wfsc_in_if.sv */
`timescale 1ns / 1ps

interface wfsc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        auto_mode;
  logic [15:0] left_distance;
  logic [15:0] center_distance;
  logic [15:0] right_distance;

  modport source (
    output valid, now_ms, auto_mode, left_distance, center_distance, right_distance,
    input  ready
  );

  modport sink (
    input  valid, now_ms, auto_mode, left_distance, center_distance, right_distance,
    output ready
  );
endinterface

/* hdl/wfsc_out_if.sv */
`timescale 1ns / 1ps

interface wfsc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  trigger_sensor;
  logic [2:0]  motor_action;
  logic [10:0] left_speed;
  logic [10:0] right_speed;

  modport source (
    output valid, trigger_sensor, motor_action, left_speed, right_speed,
    input  ready
  );

  modport sink (
    input  valid, trigger_sensor, motor_action, left_speed, right_speed,
    output ready
  );
endinterface

/* hdl/wfsc_steer.sv */
`timescale 1ns / 1ps

module wfsc_steer (
  input  logic [wfsc_pkg::ClampW-1:0] l_dist_i,
  input  logic [wfsc_pkg::ClampW-1:0] r_dist_i,
  input  logic [11:0]                 near_wall_i,
  input  logic [9:0]                  cruise_speed_i,
  output logic [wfsc_pkg::SpeedW-1:0] left_speed_o,
  output logic [wfsc_pkg::SpeedW-1:0] right_speed_o
);
  import wfsc_pkg::*;

  logic signed [11:0] diff;
  logic signed [16:0] diff_x;
  logic signed [16:0] prod;
  logic signed [12:0] quot;
  logic signed [8:0]  p_corr;
  logic signed [8:0]  corr;
  logic signed [11:0] base_x;
  logic signed [11:0] corr_x;
  logic signed [11:0] ls_raw;
  logic signed [11:0] rs_raw;

  // Proportional term: (l - r) * 18 as shift-add
  assign diff   = $signed({1'b0, l_dist_i}) - $signed({1'b0, r_dist_i});
  assign diff_x = {{5{diff[11]}}, diff};
  assign prod   = (diff_x <<< 4) + (diff_x <<< 1);

  // Divide by 16 rounding toward zero
  assign quot = $signed(prod[16:4]) + $signed({12'd0, prod[16] & (|prod[3:0])});

  // Saturate the proportional correction
  always_comb begin
    if (quot > SatCorr) begin
      p_corr = SatCorrPos;
    end else if (quot < -SatCorr) begin
      p_corr = SatCorrNeg;
    end else begin
      p_corr = quot[8:0];
    end
  end

  // Near a wall use the strong correction, left wall first
  always_comb begin
    if ({1'b0, l_dist_i} < near_wall_i) begin
      corr = StrongNeg;
    end else if ({1'b0, r_dist_i} < near_wall_i) begin
      corr = StrongPos;
    end else begin
      corr = p_corr;
    end
  end

  assign base_x = $signed({2'b00, cruise_speed_i});
  assign corr_x = {{3{corr[8]}}, corr};
  assign ls_raw = base_x - corr_x;
  assign rs_raw = base_x + corr_x;

  // Clamp wheel speeds to the legal range
  always_comb begin
    if (ls_raw < 0) begin
      left_speed_o = '0;
    end else if (ls_raw > SpeedMax) begin
      left_speed_o = SpeedMax[SpeedW-1:0];
    end else begin
      left_speed_o = ls_raw[SpeedW-1:0];
    end
    if (rs_raw < 0) begin
      right_speed_o = '0;
    end else if (rs_raw > SpeedMax) begin
      right_speed_o = SpeedMax[SpeedW-1:0];
    end else begin
      right_speed_o = rs_raw[SpeedW-1:0];
    end
  end

endmodule

/* hdl/wall_following_steering_controller_unit.sv */
`timescale 1ns / 1ps
// Wall-following steering controller.
// in_i carries one poll per beat: millisecond tick, auto flag and the left,
// center and right distances in 1/16 cm. out_o returns one beat per poll with
// the sensor trigger, motor action and two wheel speeds.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i); the
// user writes it only while no poll is in flight; the block does not enforce it.
// A poll is captured in the input register, evaluated from there, and its
// result is loaded into the output register.
// Throughput: one poll per cycle while out_o does not stall; the slot timer,
// rotation and turn state all update in the same cycle the poll is
// evaluated, so the next poll sees them. When out_o stalls, the output
// register holds its beat and the input register still takes one more poll;
// after that in_i.ready drops until the result beat is taken.
// Reset clears both pipeline valids and all controller state, and loads the
// configuration registers with their default values.
module wall_following_steering_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wfsc_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [wfsc_pkg::CfgDataW-1:0] cfg_wdata_i,
  wfsc_in_if.sink                       in_i,
  wfsc_out_if.source                    out_o
);
  import wfsc_pkg::*;

  cfg_t cfg_q;

  // Input register
  logic              s1_valid_q;
  logic [TimeW-1:0]  s1_now_q;
  logic              s1_auto_q;
  logic [DistW-1:0]  s1_left_q;
  logic [DistW-1:0]  s1_center_q;
  logic [DistW-1:0]  s1_right_q;

  // Controller state
  logic [TimeW-1:0]  last_slot_q, last_slot_d;
  logic [1:0]        slot_q, slot_d;
  logic              turning_q, turning_d;
  logic [TimeW-1:0]  turn_start_q, turn_start_d;
  logic [TimeW-1:0]  turn_end_q, turn_end_d;

  // Result register
  logic              out_valid_q;
  trig_e             trig_q, trig_d;
  act_e              act_q, act_d;
  logic [SpeedW-1:0] ls_q, ls_d;
  logic [SpeedW-1:0] rs_q, rs_d;

  logic              out_load;
  logic [TimeW-1:0]  slot_elapsed;
  logic [TimeW-1:0]  turn_elapsed;
  logic [TimeW-1:0]  idle_elapsed;
  logic              slot_due;
  logic [ClampW-1:0] l_cl, c_cl, r_cl;
  logic [SpeedW-1:0] fwd_ls, fwd_rs;

  // Handshake: output register frees up, input register moves along
  assign out_load  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || out_load;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_period_ms     <= 10'd20;
      cfg_q.turn_timeout_ms    <= 14'd450;
      cfg_q.turn_cooldown_ms   <= 14'd600;
      cfg_q.corner_distance    <= 12'd416;
      cfg_q.clear_distance     <= 12'd512;
      cfg_q.near_wall_distance <= 12'd176;
      cfg_q.cruise_speed       <= 10'd400;
      cfg_q.turn_speed         <= 10'd650;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SLOT_PERIOD:   cfg_q.slot_period_ms     <= cfg_wdata_i[9:0];
        REG_TURN_TIMEOUT:  cfg_q.turn_timeout_ms    <= cfg_wdata_i[13:0];
        REG_TURN_COOLDOWN: cfg_q.turn_cooldown_ms   <= cfg_wdata_i[13:0];
        REG_CORNER_DIST:   cfg_q.corner_distance    <= cfg_wdata_i[11:0];
        REG_CLEAR_DIST:    cfg_q.clear_distance     <= cfg_wdata_i[11:0];
        REG_NEAR_WALL:     cfg_q.near_wall_distance <= cfg_wdata_i[11:0];
        REG_CRUISE_SPEED:  cfg_q.cruise_speed       <= cfg_wdata_i[9:0];
        REG_TURN_SPEED:    cfg_q.turn_speed         <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Capture the poll payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_now_q    <= in_i.now_ms;
      s1_auto_q   <= in_i.auto_mode;
      s1_left_q   <= in_i.left_distance;
      s1_center_q <= in_i.center_distance;
      s1_right_q  <= in_i.right_distance;
    end
  end

  // Clamped distances and forward steering
  assign l_cl = clamp_dist(s1_left_q);
  assign c_cl = clamp_dist(s1_center_q);
  assign r_cl = clamp_dist(s1_right_q);

  wfsc_steer u_steer (
    .l_dist_i       (l_cl),
    .r_dist_i       (r_cl),
    .near_wall_i    (cfg_q.near_wall_distance),
    .cruise_speed_i (cfg_q.cruise_speed),
    .left_speed_o   (fwd_ls),
    .right_speed_o  (fwd_rs)
  );

  // Elapsed times, modulo 2^32
  assign slot_elapsed = s1_now_q - last_slot_q;
  assign turn_elapsed = s1_now_q - turn_start_q;
  assign idle_elapsed = s1_now_q - turn_end_q;
  assign slot_due     = slot_elapsed >= {22'd0, cfg_q.slot_period_ms};

  // Slot rotation and turn state machine
  always_comb begin
    last_slot_d  = last_slot_q;
    slot_d       = slot_q;
    turning_d    = turning_q;
    turn_start_d = turn_start_q;
    turn_end_d   = turn_end_q;
    trig_d       = TRIG_NONE;
    act_d        = ACT_NONE;
    ls_d         = '0;
    rs_d         = '0;

    if (!s1_auto_q) begin
      turning_d = 1'b0;
    end else if (slot_due) begin
      case (slot_q)
        2'd0: trig_d = TRIG_LEFT;
        2'd1: trig_d = TRIG_CENTER;
        default: begin
          trig_d = TRIG_RIGHT;
          if (turning_q) begin
            // End the turn when the front opens up or it runs too long
            if ({1'b0, c_cl} > cfg_q.clear_distance ||
                turn_elapsed > {18'd0, cfg_q.turn_timeout_ms}) begin
              act_d      = ACT_STOP;
              turning_d  = 1'b0;
              turn_end_d = s1_now_q;
            end
          end else if ({1'b0, c_cl} < cfg_q.corner_distance &&
                       idle_elapsed > {18'd0, cfg_q.turn_cooldown_ms}) begin
            // Start a turn toward the more open side
            act_d        = (l_cl >= r_cl) ? ACT_TURN_LEFT : ACT_TURN_RIGHT;
            ls_d         = {1'b0, cfg_q.turn_speed};
            rs_d         = {1'b0, cfg_q.turn_speed};
            turn_start_d = s1_now_q;
            turning_d    = 1'b1;
          end else begin
            act_d = ACT_FORWARD;
            ls_d  = fwd_ls;
            rs_d  = fwd_rs;
          end
        end
      endcase
      slot_d      = (slot_q >= 2'd2) ? 2'd0 : slot_q + 2'd1;
      last_slot_d = s1_now_q;
    end
  end

  // Controller state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_slot_q  <= '0;
      slot_q       <= '0;
      turning_q    <= 1'b0;
      turn_start_q <= '0;
      turn_end_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_load) begin
        last_slot_q  <= last_slot_d;
        slot_q       <= slot_d;
        turning_q    <= turning_d;
        turn_start_q <= turn_start_d;
        turn_end_q   <= turn_end_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      trig_q <= trig_d;
      act_q  <= act_d;
      ls_q   <= ls_d;
      rs_q   <= rs_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.trigger_sensor = trig_q;
  assign out_o.motor_action   = act_q;
  assign out_o.left_speed     = ls_q;
  assign out_o.right_speed    = rs_q;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import wfsc_pkg::*;

  // Steering arithmetic, distances in 1/16 cm
  localparam int unsigned DeadZoneDist = 40;
  localparam int unsigned FarDist      = 1920;
  localparam int unsigned FarClip      = 1600;
  localparam int          GainNum      = 18;
  localparam int          GainDen      = 16;
  localparam int          CorrLimit    = 180;
  localparam int          StrongCorr   = 250;
  localparam int          WheelMax     = 1250;

  // Run shape
  localparam int unsigned MaxGap        = 16;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned DrainCycles   = 4;
  localparam logic [31:0] DirStep       = 32'd20;

  localparam cfg_t DefaultCfg = cfg_t'{
    slot_period_ms:     10'd20,
    turn_timeout_ms:    14'd450,
    turn_cooldown_ms:   14'd600,
    corner_distance:    12'd416,
    clear_distance:     12'd512,
    near_wall_distance: 12'd176,
    cruise_speed:       10'd400,
    turn_speed:         10'd650
  };

  typedef struct packed {
    logic [31:0] now_ms;
    logic        auto_mode;
    logic [15:0] left_distance;
    logic [15:0] center_distance;
    logic [15:0] right_distance;
  } poll_t;

  typedef struct packed {
    trig_e       trigger_sensor;
    act_e        motor_action;
    logic [10:0] left_speed;
    logic [10:0] right_speed;
  } steer_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [RegIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  wfsc_in_if  in_bus ();
  wfsc_out_if out_bus ();

  wall_following_steering_controller_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // Controller state as the testbench tracks it
  cfg_t        ctrl_cfg;
  trig_e       next_sensor;
  logic        in_turn;
  logic [31:0] slot_mark_ms;
  logic [31:0] turn_began_ms;
  logic [31:0] turn_ended_ms;

  poll_t       poll_q [$];
  steer_t      steer_q [$];
  poll_t       offered;
  logic [31:0] last_now;

  int unsigned src_gap_max;
  int unsigned snk_gap_max;
  int unsigned gap_left;
  int unsigned rdy_wait;

  int unsigned polls_taken;
  int unsigned beats_checked;
  int unsigned err_count;
  int unsigned turns_seen;
  int unsigned stops_seen;
  int unsigned forwards_seen;
  int unsigned settings_used;

  always #1 clk_i = ~clk_i;

  // Zero the dead zone, pull far echoes in
  function automatic int unsigned trim_dist(input logic [15:0] d);
    if (d <= DeadZoneDist) return 0;
    if (d > FarDist) return FarClip;
    return d;
  endfunction

  function automatic logic [10:0] wheel_speed(input int v);
    if (v < 0) return '0;
    if (v > WheelMax) return 11'(WheelMax);
    return 11'(v);
  endfunction

  // Work out the steering beat for one poll and advance the tracked state
  function automatic steer_t predict_steer(input poll_t p);
    steer_t      s;
    logic [31:0] since_slot;
    logic [31:0] turn_age;
    logic [31:0] rest_age;
    int unsigned l;
    int unsigned c;
    int unsigned r;
    int          corr;
    s.trigger_sensor = TRIG_NONE;
    s.motor_action   = ACT_NONE;
    s.left_speed     = '0;
    s.right_speed    = '0;
    since_slot = p.now_ms - slot_mark_ms;
    turn_age   = p.now_ms - turn_began_ms;
    rest_age   = p.now_ms - turn_ended_ms;
    if (!p.auto_mode) begin
      in_turn = 1'b0;
    end else if (since_slot >= ctrl_cfg.slot_period_ms) begin
      s.trigger_sensor = next_sensor;
      if (next_sensor == TRIG_RIGHT) begin
        l = trim_dist(p.left_distance);
        c = trim_dist(p.center_distance);
        r = trim_dist(p.right_distance);
        if (in_turn) begin
          // end the turn on a clear front or once it has run too long
          if (c > ctrl_cfg.clear_distance || turn_age > ctrl_cfg.turn_timeout_ms) begin
            s.motor_action = ACT_STOP;
            in_turn        = 1'b0;
            turn_ended_ms  = p.now_ms;
          end
        end else if (c < ctrl_cfg.corner_distance && rest_age > ctrl_cfg.turn_cooldown_ms) begin
          // turn toward the more open side, left on a tie
          s.motor_action = (l >= r) ? ACT_TURN_LEFT : ACT_TURN_RIGHT;
          s.left_speed   = 11'(ctrl_cfg.turn_speed);
          s.right_speed  = 11'(ctrl_cfg.turn_speed);
          turn_began_ms  = p.now_ms;
          in_turn        = 1'b1;
        end else begin
          // left wall rule first, then right, then proportional centering
          if (l < ctrl_cfg.near_wall_distance) begin
            corr = -StrongCorr;
          end else if (r < ctrl_cfg.near_wall_distance) begin
            corr = StrongCorr;
          end else begin
            corr = ((int'(l) - int'(r)) * GainNum) / GainDen;
            if (corr > CorrLimit) corr = CorrLimit;
            if (corr < -CorrLimit) corr = -CorrLimit;
          end
          s.motor_action = ACT_FORWARD;
          s.left_speed   = wheel_speed(int'(ctrl_cfg.cruise_speed) - corr);
          s.right_speed  = wheel_speed(int'(ctrl_cfg.cruise_speed) + corr);
        end
      end
      case (next_sensor)
        TRIG_LEFT:   next_sensor = TRIG_CENTER;
        TRIG_CENTER: next_sensor = TRIG_RIGHT;
        default:     next_sensor = TRIG_LEFT;
      endcase
      slot_mark_ms = p.now_ms;
    end
    return s;
  endfunction

  function automatic int unsigned draw_gap(input int unsigned lim);
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, lim);
  endfunction

  // Distances clustered on the clamps and the current thresholds
  function automatic logic [15:0] pick_dist();
    int v;
    case ($urandom_range(0, 7))
      0:       v = $urandom_range(0, 45);
      1:       v = int'(ctrl_cfg.corner_distance) + $urandom_range(0, 6) - 3;
      2:       v = int'(ctrl_cfg.clear_distance) + $urandom_range(0, 6) - 3;
      3:       v = int'(ctrl_cfg.near_wall_distance) + $urandom_range(0, 6) - 3;
      4:       v = $urandom_range(1910, 1930);
      5:       v = $urandom_range(0, 65535);
      default: v = $urandom_range(41, 1920);
    endcase
    if (v < 0) v = 0;
    return v[15:0];
  endfunction

  task automatic queue_poll(input poll_t pl);
    poll_q.push_back(pl);
    last_now = pl.now_ms;
  endtask

  // Left and center slots carry noise, the right slot carries the given distances
  task automatic queue_rotation(input logic [31:0] t0, input logic [15:0] l,
                                input logic [15:0] c, input logic [15:0] r);
    queue_poll(poll_t'{t0, 1'b1, 16'($urandom()), 16'($urandom()), 16'($urandom())});
    queue_poll(poll_t'{t0 + DirStep, 1'b1, 16'($urandom()), 16'($urandom()),
                       16'($urandom())});
    queue_poll(poll_t'{t0 + 2 * DirStep, 1'b1, l, c, r});
  endtask

  // Mostly polls that land a slot, some early ones, long jumps and manual mode
  task automatic queue_random(input int unsigned n);
    poll_t       pl;
    int unsigned roll;
    logic [31:0] per;
    per = 32'(ctrl_cfg.slot_period_ms);
    for (int unsigned k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        pl.now_ms = last_now + per + $urandom_range(0, 3);
      end else if (roll < 82) begin
        pl.now_ms = last_now + $urandom_range(0, per);
      end else if (roll < 96) begin
        pl.now_ms = last_now + $urandom_range(0, 3000);
      end else begin
        pl.now_ms = $urandom();
      end
      pl.auto_mode       = ($urandom_range(0, 99) >= 7);
      pl.left_distance   = pick_dist();
      pl.center_distance = pick_dist();
      pl.right_distance  = pick_dist();
      queue_poll(pl);
    end
  endtask

  task automatic put_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t s);
    @(posedge clk_i);
    put_reg(REG_SLOT_PERIOD, s.slot_period_ms);
    put_reg(REG_TURN_TIMEOUT, s.turn_timeout_ms);
    put_reg(REG_TURN_COOLDOWN, s.turn_cooldown_ms);
    put_reg(REG_CORNER_DIST, s.corner_distance);
    put_reg(REG_CLEAR_DIST, s.clear_distance);
    put_reg(REG_NEAR_WALL, s.near_wall_distance);
    put_reg(REG_CRUISE_SPEED, s.cruise_speed);
    put_reg(REG_TURN_SPEED, s.turn_speed);
    cfg_we_i <= 1'b0;
    ctrl_cfg = s;
    settings_used++;
  endtask

  // Wait until every poll is taken and every steering beat has come back
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (poll_q.size() != 0 || in_bus.valid || steer_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Offer queued polls, predict each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    steer_t want;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        want = predict_steer(offered);
        steer_q.push_back(want);
        polls_taken++;
        case (want.motor_action)
          ACT_TURN_LEFT, ACT_TURN_RIGHT: turns_seen++;
          ACT_STOP:                      stops_seen++;
          ACT_FORWARD:                   forwards_seen++;
          default: ;
        endcase
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (poll_q.size() != 0) begin
          offered = poll_q.pop_front();
          in_bus.valid           <= 1'b1;
          in_bus.now_ms          <= offered.now_ms;
          in_bus.auto_mode       <= offered.auto_mode;
          in_bus.left_distance   <= offered.left_distance;
          in_bus.center_distance <= offered.center_distance;
          in_bus.right_distance  <= offered.right_distance;
          gap_left = draw_gap(src_gap_max);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Take steering beats, compare against the oldest prediction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    steer_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      rdy_wait = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (steer_q.size() == 0) begin
          $error("steering beat with no poll pending");
          err_count++;
        end else begin
          want = steer_q.pop_front();
          if (out_bus.trigger_sensor !== want.trigger_sensor) begin
            $error("trigger_sensor: expected %0d, got %0d",
                   want.trigger_sensor, out_bus.trigger_sensor);
            err_count++;
          end
          if (out_bus.motor_action !== want.motor_action) begin
            $error("motor_action: expected %0d, got %0d",
                   want.motor_action, out_bus.motor_action);
            err_count++;
          end
          if (out_bus.left_speed !== want.left_speed) begin
            $error("left_speed: expected %0d, got %0d", want.left_speed, out_bus.left_speed);
            err_count++;
          end
          if (out_bus.right_speed !== want.right_speed) begin
            $error("right_speed: expected %0d, got %0d", want.right_speed, out_bus.right_speed);
            err_count++;
          end
        end
        beats_checked++;
        // hold off twice for long enough to back the block up
        if (beats_checked == 40 || beats_checked == 300) begin
          rdy_wait = HoldOffCycles;
        end else begin
          rdy_wait = draw_gap(snk_gap_max);
        end
      end
      if (rdy_wait != 0) begin
        rdy_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    cfg_t mix_cfg;
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = REG_SLOT_PERIOD;
    cfg_wdata_i            = '0;
    in_bus.valid           = 1'b0;
    in_bus.now_ms          = '0;
    in_bus.auto_mode       = 1'b0;
    in_bus.left_distance   = '0;
    in_bus.center_distance = '0;
    in_bus.right_distance  = '0;
    out_bus.ready          = 1'b0;
    ctrl_cfg      = DefaultCfg;
    next_sensor   = TRIG_LEFT;
    in_turn       = 1'b0;
    slot_mark_ms  = '0;
    turn_began_ms = '0;
    turn_ended_ms = '0;
    last_now      = '0;
    src_gap_max   = MaxGap;
    snk_gap_max   = MaxGap;
    settings_used = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk through the turn cycle under reset settings
    queue_poll(poll_t'{32'd0, 1'b1, 16'd0, 16'd0, 16'd0});
    queue_poll(poll_t'{32'd5, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    // far clamp on left and center, correction saturates
    queue_rotation(32'd20, 16'hFFFF, 16'hFFFF, 16'd200);
    // front in the dead zone, sides tie: turn left
    queue_rotation(32'd700, 16'd41, 16'd40, 16'd41);
    // front opens up: stop
    queue_rotation(32'd760, 16'd500, 16'd600, 16'd500);
    // still cooling down, both walls near: left wall rule
    queue_rotation(32'd820, 16'd100, 16'd0, 16'd100);
    // right side more open: turn right
    queue_rotation(32'd1500, 16'd300, 16'd0, 16'd1900);
    // front stays blocked until the turn times out
    queue_rotation(32'd2000, 16'd300, 16'd0, 16'd300);
    // right wall near, just before the tick wraps
    queue_rotation(32'hFFFF_FFC0, 16'd1000, 16'd1000, 16'd50);
    // across the wrap, small negative correction truncates toward zero
    queue_rotation(32'hFFFF_FFFF, 16'd500, 16'd1000, 16'd501);
    wait_drained();

    queue_random(80);
    wait_drained();

    // Lowest legal settings, no idling on either side
    src_gap_max = 0;
    snk_gap_max = 0;
    load_settings(cfg_t'{
      slot_period_ms: 10'd1, turn_timeout_ms: 14'd1, turn_cooldown_ms: 14'd0,
      corner_distance: 12'd0, clear_distance: 12'd0, near_wall_distance: 12'd0,
      cruise_speed: 10'd250, turn_speed: 10'd0});
    queue_random(80);
    wait_drained();

    // Highest legal settings, receiver always ready
    src_gap_max = MaxGap;
    snk_gap_max = 0;
    load_settings(cfg_t'{
      slot_period_ms: 10'd1000, turn_timeout_ms: 14'd10000, turn_cooldown_ms: 14'd10000,
      corner_distance: 12'd4095, clear_distance: 12'd4095, near_wall_distance: 12'd4095,
      cruise_speed: 10'd1000, turn_speed: 10'd1000});
    queue_random(80);
    wait_drained();

    // Zero slot period, cruise speed of zero, full-width timers
    src_gap_max = 0;
    snk_gap_max = MaxGap;
    load_settings(cfg_t'{
      slot_period_ms: 10'd0, turn_timeout_ms: 14'h3FFF, turn_cooldown_ms: 14'h3FFF,
      corner_distance: 12'd600, clear_distance: 12'd300, near_wall_distance: 12'd300,
      cruise_speed: 10'd0, turn_speed: 10'h3FF});
    queue_random(80);
    wait_drained();

    // Cruise speed past its range so forward speeds clip high
    src_gap_max = MaxGap;
    snk_gap_max = MaxGap;
    mix_cfg.slot_period_ms     = 10'($urandom_range(1, 50));
    mix_cfg.turn_timeout_ms    = 14'($urandom_range(1, 600));
    mix_cfg.turn_cooldown_ms   = 14'($urandom_range(0, 600));
    mix_cfg.corner_distance    = 12'($urandom_range(200, 1000));
    mix_cfg.clear_distance     = 12'($urandom_range(300, 1200));
    mix_cfg.near_wall_distance = 12'($urandom_range(50, 400));
    mix_cfg.cruise_speed       = 10'h3FF;
    mix_cfg.turn_speed         = 10'($urandom_range(0, 1000));
    load_settings(mix_cfg);
    queue_random(90);
    wait_drained();

    // Random legal settings with short timers, light idling
    src_gap_max = 3;
    snk_gap_max = 3;
    mix_cfg.slot_period_ms     = 10'($urandom_range(1, 50));
    mix_cfg.turn_timeout_ms    = 14'($urandom_range(1, 300));
    mix_cfg.turn_cooldown_ms   = 14'($urandom_range(0, 300));
    mix_cfg.corner_distance    = 12'($urandom_range(0, 4095));
    mix_cfg.clear_distance     = 12'($urandom_range(0, 4095));
    mix_cfg.near_wall_distance = 12'($urandom_range(0, 4095));
    mix_cfg.cruise_speed       = 10'($urandom_range(250, 1000));
    mix_cfg.turn_speed         = 10'($urandom_range(0, 1000));
    load_settings(mix_cfg);
    queue_random(90);
    wait_drained();

    $display("tb_top: %0d polls taken, %0d steering beats compared, %0d register settings",
             polls_taken, beats_checked, settings_used);
    $display("tb_top: predicted %0d turns, %0d stops, %0d forward drives",
             turns_seen, stops_seen, forwards_seen);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #400000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
hdl/wfsc_pkg.sv
hdl/wfsc_in_if.sv
hdl/wfsc_out_if.sv
hdl/wfsc_steer.sv
hdl/wall_following_steering_controller_unit.sv
tb/sv/tb_top.sv
